// ----- rtl/core/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared widths, register indexes and inter-module types of the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int OUT_BITS    = BYTE_W + IDX_W + LEN_W;
  localparam int TDATA_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 8;

  localparam logic [CFG_AW-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_LENGTH  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

endpackage

// ----- rtl/core/cfr_ram.sv -----
// ----------------------------------------------------------------------------
// cfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/cfr_parser.sv -----
// ----------------------------------------------------------------------------
// cfr_parser
// Front end: sync hunt, length check, payload store, Fletcher-style check.
// ----------------------------------------------------------------------------
module cfr_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  cfr_pkg::cfg_t                 cfg,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cfr_pkg::BYTE_W-1:0]    s_tdata,
  input  logic                          q_full,
  output logic                          push,
  output cfr_pkg::desc_t                push_desc,
  output cfr_pkg::wr_t                  wr
);

  typedef enum logic [2:0] {
    HUNT1, HUNT2, LENGTH, PAYLOAD, CHECK1, CHECK2
  } phase_t;

  phase_t                        phase;
  logic [cfr_pkg::LEN_W-1:0]     expected;
  logic [cfr_pkg::LEN_W-1:0]     count;
  logic [cfr_pkg::BYTE_W-1:0]    sum_a;
  logic [cfr_pkg::BYTE_W-1:0]    sum_b;
  logic                          bank;

  logic                          take;
  logic [cfr_pkg::BYTE_W-1:0]    b;
  logic [cfr_pkg::LEN_W-1:0]     count_next;
  logic [cfr_pkg::BYTE_W-1:0]    sum_a_next;
  logic                          bad_len;

  assign s_tready   = !q_full;
  assign take       = s_tvalid && s_tready;
  assign b          = s_tdata;
  assign count_next = count + cfr_pkg::LEN_W'(1);
  assign sum_a_next = sum_a + b;
  assign bad_len    = (b == '0) || (b > {1'b0, cfg.max_length})
                   || (b > cfr_pkg::BYTE_W'(cfr_pkg::MAX_PAYLOAD));

  assign wr.en   = take && (phase == PAYLOAD);
  assign wr.addr = {bank, count[cfr_pkg::IDX_W-1:0]};
  assign wr.data = b;

  assign push          = take && (phase == CHECK2) && (b == sum_b);
  assign push_desc.len = expected;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= HUNT1;
      expected <= '0;
      count    <= '0;
      sum_a    <= '0;
      sum_b    <= '0;
      bank     <= 1'b0;
    end else if (take) begin
      unique case (phase)
        HUNT2: begin
          phase <= (b == cfg.sync_second) ? LENGTH : HUNT1;
        end
        LENGTH: begin
          if (bad_len) begin
            phase <= HUNT1;
          end else begin
            expected <= b[cfr_pkg::LEN_W-1:0];
            count    <= '0;
            sum_a    <= b;
            sum_b    <= b;
            phase    <= PAYLOAD;
          end
        end
        PAYLOAD: begin
          count <= count_next;
          sum_a <= sum_a_next;
          sum_b <= sum_b + sum_a_next;
          if (count_next >= expected) begin
            phase <= CHECK1;
          end
        end
        CHECK1: begin
          phase <= (b == sum_a) ? CHECK2 : HUNT1;
        end
        CHECK2: begin
          phase <= HUNT1;
          if (b == sum_b) begin
            bank <= ~bank;
          end
        end
        default: begin
          phase <= (b == cfg.sync_first) ? HUNT2 : HUNT1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/cfr_queue.sv -----
// ----------------------------------------------------------------------------
// cfr_queue
// Two-entry descriptor queue; one entry per filled payload bank.
// ----------------------------------------------------------------------------
module cfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cfr_pkg::desc_t push_desc,
  input  logic           pop,
  output cfr_pkg::desc_t head,
  output logic           empty,
  output logic           full
);

  cfr_pkg::desc_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign head  = slots[rptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("descriptor pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("descriptor popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) || (count == 2'd1) || (count == 2'd2))
    else $error("queue count out of range");

endmodule

// ----- rtl/core/cfr_drain.sv -----
// ----------------------------------------------------------------------------
// cfr_drain
// Back end: reads a stored payload bank and streams it out byte by byte.
// ----------------------------------------------------------------------------
module cfr_drain (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  cfr_pkg::desc_t                    head,
  output logic                              pop,
  output logic                              rd_en,
  output logic [cfr_pkg::RAM_AW-1:0]        rd_addr,
  input  logic [cfr_pkg::BYTE_W-1:0]        rd_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cfr_pkg::TDATA_W-1:0]       m_tdata,
  output logic                              m_tlast
);

  logic                          rbank;
  logic [cfr_pkg::IDX_W-1:0]     idx;
  logic [cfr_pkg::IDX_W-1:0]     out_idx;
  logic [cfr_pkg::LEN_W-1:0]     out_len;

  logic                          advance;
  logic                          issue;
  logic                          at_last;

  assign advance = !m_tvalid || m_tready;
  assign issue   = advance && !q_empty;
  assign at_last = ({1'b0, idx} == (head.len - cfr_pkg::LEN_W'(1)));
  assign pop     = issue && at_last;
  assign rd_en   = issue;
  assign rd_addr = {rbank, idx};
  assign m_tdata = {{(cfr_pkg::TDATA_W - cfr_pkg::OUT_BITS){1'b0}}, out_len, out_idx, rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      idx      <= '0;
      rbank    <= 1'b0;
    end else if (advance) begin
      m_tvalid <= issue;
      if (issue) begin
        out_idx <= idx;
        out_len <= head.len;
        m_tlast <= at_last;
        if (at_last) begin
          idx   <= '0;
          rbank <= ~rbank;
        end else begin
          idx <= idx + cfr_pkg::IDX_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/core/checksummed_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_core
// Framed byte-stream receiver with additive checksum and payload replay.
//
//   port group   dir  contents
//   s_*          in   received byte, tdata[7:0] = rx_byte
//   m_*          out  payload byte, tdata[7:0] data_byte, [13:8] byte_index,
//                     [20:14] frame_length; tlast = last
//   cfg_*        in   register write, 0 sync_first, 1 sync_second, 2 max_length
//
// One received byte per cycle while s_tready; one payload byte per cycle
// out while m_tready. A good frame is queued on its second check byte.
// Payload banks: two; s_tready drops while both hold frames awaiting drain.
// Reset is synchronous and clears parser, queue and output valid.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cfr_pkg::TDATA_W-1:0]     m_tdata,  // data_byte, byte_index, frame_length
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [cfr_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [cfr_pkg::CFG_DW-1:0]      cfg_data
);

  cfr_pkg::cfg_t                  cfg;
  cfr_pkg::wr_t                   wr;
  cfr_pkg::desc_t                 push_desc;
  cfr_pkg::desc_t                 head;
  logic                           push;
  logic                           pop;
  logic                           q_empty;
  logic                           q_full;
  logic                           rd_en;
  logic [cfr_pkg::RAM_AW-1:0]     rd_addr;
  logic [cfr_pkg::BYTE_W-1:0]     rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= '0;
      cfg.sync_second <= '0;
      cfg.max_length  <= cfr_pkg::LEN_W'(cfr_pkg::MAX_PAYLOAD);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cfr_pkg::REG_SYNC_FIRST:  cfg.sync_first  <= cfg_data;
        cfr_pkg::REG_SYNC_SECOND: cfg.sync_second <= cfg_data;
        cfr_pkg::REG_MAX_LENGTH:  cfg.max_length  <= cfg_data[cfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  cfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr)
  );

  cfr_ram #(
    .WIDTH (cfr_pkg::BYTE_W),
    .DEPTH (cfr_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cfr_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
